@@ rtl/wqgr_pkg.sv @@
package wqgr_pkg;

    // Field widths
    localparam int unsigned PH_W    = 11;
    localparam int unsigned TURB_W  = 12;
    localparam int unsigned LEVEL_W = 10;
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned ROUTE_W = 3;
    localparam int unsigned STRK_W  = 2;

    // Configuration port
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Fixed temperature window, tenths of a degree Celsius
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 12'sd100;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd400;

    // Streak counters saturate here
    localparam logic [STRK_W-1:0] STREAK_LIMIT = 2'd3;

    // Register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_PH_MIN         = 3'd0,
        REG_PH_MAX         = 3'd1,
        REG_TURB_MAX       = 3'd2,
        REG_LEVEL_HIGH     = 3'd3,
        REG_LEVEL_LOW      = 3'd4,
        REG_LEVEL_OVERFLOW = 3'd5,
        REG_LEVEL_RESUME   = 3'd6,
        REG_UP_OVERFLOW    = 3'd7
    } reg_idx_t;

    // Route codes
    typedef enum logic [ROUTE_W-1:0] {
        ROUTE_NONE    = 3'd0,
        ROUTE_STOPPED = 3'd1,
        ROUTE_HOLD    = 3'd2,
        ROUTE_STORE   = 3'd3,
        ROUTE_RECYCLE = 3'd4
    } route_t;

    // Item modes
    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;

    // Configuration register set
    typedef struct packed {
        logic [PH_W-1:0]    ph_min;
        logic [PH_W-1:0]    ph_max;
        logic [TURB_W-1:0]  turbidity_max;
        logic [LEVEL_W-1:0] level_high;
        logic [LEVEL_W-1:0] level_low;
        logic [LEVEL_W-1:0] level_overflow;
        logic [LEVEL_W-1:0] level_resume;
        logic [LEVEL_W-1:0] upstream_overflow;
    } cfg_t;

    // One input transaction
    typedef struct packed {
        logic                     mode;
        logic [LEVEL_W-1:0]       level_here;
        logic [LEVEL_W-1:0]       level_upstream;
        logic                     here_calibrated;
        logic                     upstream_calibrated;
        logic [PH_W-1:0]          ph_reading;
        logic [TURB_W-1:0]        turbidity_reading;
        logic signed [TEMP_W-1:0] temperature_reading;
    } item_t;

    // One result transaction
    typedef struct packed {
        route_t            route;
        logic              route_changed;
        logic              inflow_stop;
        logic              overflow_event;
        logic              quality_ok;
        logic [STRK_W-1:0] pass_streak;
        logic [STRK_W-1:0] fail_streak;
    } result_t;

endpackage

@@ rtl/wqgr_regs.sv @@
module wqgr_regs
    import wqgr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PH_MIN:         cfg_next.ph_min            = pwdata[PH_W-1:0];
                REG_PH_MAX:         cfg_next.ph_max            = pwdata[PH_W-1:0];
                REG_TURB_MAX:       cfg_next.turbidity_max     = pwdata[TURB_W-1:0];
                REG_LEVEL_HIGH:     cfg_next.level_high        = pwdata[LEVEL_W-1:0];
                REG_LEVEL_LOW:      cfg_next.level_low         = pwdata[LEVEL_W-1:0];
                REG_LEVEL_OVERFLOW: cfg_next.level_overflow    = pwdata[LEVEL_W-1:0];
                REG_LEVEL_RESUME:   cfg_next.level_resume      = pwdata[LEVEL_W-1:0];
                REG_UP_OVERFLOW:    cfg_next.upstream_overflow = pwdata[LEVEL_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ph_min            <= 11'd650;
            cfg_reg.ph_max            <= 11'd850;
            cfg_reg.turbidity_max     <= 12'd50;
            cfg_reg.level_high        <= 10'd250;
            cfg_reg.level_low         <= 10'd100;
            cfg_reg.level_overflow    <= 10'd900;
            cfg_reg.level_resume      <= 10'd800;
            cfg_reg.upstream_overflow <= 10'd900;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_PH_MIN:         prdata[PH_W-1:0]    = cfg_reg.ph_min;
            REG_PH_MAX:         prdata[PH_W-1:0]    = cfg_reg.ph_max;
            REG_TURB_MAX:       prdata[TURB_W-1:0]  = cfg_reg.turbidity_max;
            REG_LEVEL_HIGH:     prdata[LEVEL_W-1:0] = cfg_reg.level_high;
            REG_LEVEL_LOW:      prdata[LEVEL_W-1:0] = cfg_reg.level_low;
            REG_LEVEL_OVERFLOW: prdata[LEVEL_W-1:0] = cfg_reg.level_overflow;
            REG_LEVEL_RESUME:   prdata[LEVEL_W-1:0] = cfg_reg.level_resume;
            REG_UP_OVERFLOW:    prdata[LEVEL_W-1:0] = cfg_reg.upstream_overflow;
        endcase
    end

endmodule

@@ rtl/wqgr_quality.sv @@
module wqgr_quality
    import wqgr_pkg::*;
(
    input  cfg_t  cfg,
    input  item_t item,
    output logic  quality_ok
);

    logic ph_ok;
    logic turb_ok;
    logic temp_ok;

    // Window checks; an inverted window simply never passes.
    assign ph_ok   = (item.ph_reading >= cfg.ph_min) && (item.ph_reading <= cfg.ph_max);
    assign turb_ok = item.turbidity_reading <= cfg.turbidity_max;
    assign temp_ok = (item.temperature_reading >= TEMP_MIN)
                  && (item.temperature_reading <= TEMP_MAX);

    assign quality_ok = ph_ok && turb_ok && temp_ok;

endmodule

@@ rtl/wqgr_router.sv @@
module wqgr_router
    import wqgr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  item_t   item,
    input  logic    quality_ok,
    input  logic    advance,
    output result_t result
);

    logic              latch_reg;
    logic              latch_next;
    logic [STRK_W-1:0] pass_reg;
    logic [STRK_W-1:0] pass_next;
    logic [STRK_W-1:0] fail_reg;
    logic [STRK_W-1:0] fail_next;
    route_t            last_route_reg;
    route_t            last_route_next;
    result_t           result_reg;
    result_t           result_next;

    logic   at_overflow;
    logic   level_short;
    logic   blocked;
    route_t route_sel;

    assign at_overflow = item.level_here >= cfg.level_overflow;
    assign level_short = (item.level_here < cfg.level_high)
                      || (item.level_here <= cfg.level_low);
    assign blocked     = item.upstream_calibrated
                      && (item.level_upstream >= cfg.upstream_overflow);

    // Latch, streaks and route decision for one transaction
    always_comb
    begin
        latch_next      = latch_reg;
        pass_next       = pass_reg;
        fail_next       = fail_reg;
        last_route_next = last_route_reg;
        route_sel       = ROUTE_HOLD;
        result_next     = '0;

        if (item.mode == MODE_CLEAR)
        begin
            pass_next = '0;
            fail_next = '0;
        end
        else
        begin
            result_next.quality_ok = quality_ok;
            if (item.here_calibrated)
            begin
                if (at_overflow)
                begin
                    // Routing is skipped while the tank is at overflow.
                    result_next.inflow_stop = 1'b1;
                    if (!latch_reg)
                    begin
                        latch_next                 = 1'b1;
                        result_next.overflow_event = 1'b1;
                    end
                end
                else
                begin
                    if (latch_reg && (item.level_here <= cfg.level_resume))
                    begin
                        latch_next = 1'b0;
                    end
                    result_next.inflow_stop = latch_next;

                    if (level_short)
                    begin
                        route_sel = ROUTE_STOPPED;
                    end
                    else if (quality_ok)
                    begin
                        fail_next = '0;
                        if (pass_reg != STREAK_LIMIT)
                        begin
                            pass_next = pass_reg + 1'b1;
                        end
                        route_sel = (pass_next == STREAK_LIMIT) ? ROUTE_STORE : ROUTE_HOLD;
                    end
                    else
                    begin
                        pass_next = '0;
                        if (fail_reg != STREAK_LIMIT)
                        begin
                            fail_next = fail_reg + 1'b1;
                        end
                        if (fail_next == STREAK_LIMIT && !blocked)
                        begin
                            route_sel = ROUTE_RECYCLE;
                        end
                    end

                    result_next.route_changed = route_sel != last_route_reg;
                    last_route_next           = route_sel;
                end
            end
        end

        result_next.route       = last_route_next;
        result_next.pass_streak = pass_next;
        result_next.fail_streak = fail_next;
    end

    // State advances once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg      <= 1'b0;
            pass_reg       <= '0;
            fail_reg       <= '0;
            last_route_reg <= ROUTE_NONE;
        end
        else if (advance)
        begin
            latch_reg      <= latch_next;
            pass_reg       <= pass_next;
            fail_reg       <= fail_next;
            last_route_reg <= last_route_next;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

@@ rtl/water_quality_gate_router.sv @@
// Water quality gate router. Each input transaction is a sensor tick or a
// clear command; each produces exactly one result transaction carrying the
// route, change and overflow flags and the pass and fail streak counts.
// Accepted transactions enter an input register, and the decision logic
// writes a result register from it; a new transaction can be taken every
// cycle as long as the output side keeps taking results. Thresholds are
// written through the APB-style port at byte addresses 0x00 to 0x1C and
// must only be changed while no transactions are in flight.
module water_quality_gate_router
    import wqgr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    output logic [APB_DW-1:0]        prdata,
    output logic                     pready,
    // Input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     mode,
    input  logic [LEVEL_W-1:0]       level_here,
    input  logic [LEVEL_W-1:0]       level_upstream,
    input  logic                     here_calibrated,
    input  logic                     upstream_calibrated,
    input  logic [PH_W-1:0]          ph_reading,
    input  logic [TURB_W-1:0]        turbidity_reading,
    input  logic signed [TEMP_W-1:0] temperature_reading,
    // Output channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [ROUTE_W-1:0]       route,
    output logic                     route_changed,
    output logic                     inflow_stop,
    output logic                     overflow_event,
    output logic                     quality_ok,
    output logic [STRK_W-1:0]        pass_streak_out,
    output logic [STRK_W-1:0]        fail_streak_out
);

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_in;
    logic    in_valid_reg;
    logic    in_valid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    in_fire;
    logic    qok;
    result_t result;

    wqgr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pipeline handshake: the input stage moves forward when the result
    // register is empty or its transaction is being taken.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    assign in_valid_next  = in_fire || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register
    assign item_in.mode                = mode;
    assign item_in.level_here          = level_here;
    assign item_in.level_upstream      = level_upstream;
    assign item_in.here_calibrated     = here_calibrated;
    assign item_in.upstream_calibrated = upstream_calibrated;
    assign item_in.ph_reading          = ph_reading;
    assign item_in.turbidity_reading   = turbidity_reading;
    assign item_in.temperature_reading = temperature_reading;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= item_in;
        end
    end

    wqgr_quality u_quality (
        .cfg        (cfg),
        .item       (item_reg),
        .quality_ok (qok)
    );

    wqgr_router u_router (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item_reg),
        .quality_ok (qok),
        .advance    (advance),
        .result     (result)
    );

    assign out_valid       = out_valid_reg;
    assign route           = result.route;
    assign route_changed   = result.route_changed;
    assign inflow_stop     = result.inflow_stop;
    assign overflow_event  = result.overflow_event;
    assign quality_ok      = result.quality_ok;
    assign pass_streak_out = result.pass_streak;
    assign fail_streak_out = result.fail_streak;

endmodule

@@ rtl/wqgr_checker.sv @@
module wqgr_checker
    import wqgr_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [ROUTE_W-1:0] route,
    input logic               route_changed,
    input logic               inflow_stop,
    input logic               overflow_event,
    input logic [STRK_W-1:0]  pass_streak_out,
    input logic [STRK_W-1:0]  fail_streak_out
);

    // A stalled result transaction holds its route.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(route))
        else $error("result changed while stalled");

    // An overflow event always stops the inflow pump and never flags a route change.
    a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow_event |-> inflow_stop && !route_changed)
        else $error("overflow event without inflow stop");

    // A changed route is always one that was applied.
    a_changed_route: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && route_changed |-> route != ROUTE_NONE && route <= ROUTE_RECYCLE)
        else $error("route change to an invalid route");

    // The pass and fail streaks are never both running.
    a_streak_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pass_streak_out == '0 || fail_streak_out == '0)
        else $error("pass and fail streaks both nonzero");

endmodule

bind water_quality_gate_router wqgr_checker u_wqgr_checker (.*);
